@@ rtl/hpbr_pkg.sv @@
// shared types, widths, register codes and reset values of the hrv paced brightness ramp
// no dependencies; compiled first

package hpbr_pkg;

  // field widths
  localparam int unsigned HRV_W      = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned PULSE_W    = 16;
  localparam int unsigned BRT_W      = 8;
  localparam int unsigned PERM_W     = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // shared divider geometry: 26-bit dividend, 16-bit divisor, two quotient bits per cycle
  localparam int unsigned DIV_N_W     = 26;
  localparam int unsigned DIV_D_W     = 16;
  localparam int unsigned DIV_STEPS   = DIV_N_W / 2;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  // multiplier operand widths
  localparam int unsigned MUL_A_W = 17;
  localparam int unsigned MUL_B_W = 11;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [PULSE_W-1:0] PERMILLE_FULL = 16'd1000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HRV   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HRV   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK      = 3'd4;

  // register reset values
  localparam logic [HRV_W-1:0]   MIN_HRV_RST   = 16'd320;
  localparam logic [HRV_W-1:0]   MAX_HRV_RST   = 16'd1600;
  localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 16'd500;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 16'd3000;
  localparam logic [BRT_W-1:0]   PEAK_RST      = 8'd255;

  typedef struct packed {
    logic [HRV_W-1:0]   min_hrv;
    logic [HRV_W-1:0]   max_hrv;
    logic [PULSE_W-1:0] min_pulse;
    logic [PULSE_W-1:0] max_pulse;
    logic [BRT_W-1:0]   peak;
  } hpbr_cfg_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } hpbr_div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DIV_N_W-1:0] quot;
    logic [DIV_D_W-1:0] rem;
  } hpbr_div_rsp_t;

endpackage

@@ rtl/hpbr_ifs.sv @@
// valid/ready channel interfaces for update samples and brightness results
// depends on hpbr_pkg

interface hpbr_in_if import hpbr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HRV_W-1:0]  hrv_value;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, output hrv_value, output now_ms, input ready);
  modport sink (input valid, input hrv_value, input now_ms, output ready);
endinterface

interface hpbr_out_if import hpbr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BRT_W-1:0] brightness;
  logic             fading_up;

  modport source (output valid, output brightness, output fading_up, input ready);
  modport sink (input valid, input brightness, input fading_up, output ready);
endinterface

@@ rtl/hpbr_cfg_regs.sv @@
// configuration register file of the brightness ramp, write only
// depends on hpbr_pkg

module hpbr_cfg_regs import hpbr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  we_i,
  input  logic [CFG_IDX_W-1:0]  idx_i,
  input  logic [CFG_DATA_W-1:0] wdata_i,
  output hpbr_cfg_t             cfg_o
);

  hpbr_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        CFG_MIN_HRV:   cfg_d.min_hrv   = wdata_i;
        CFG_MAX_HRV:   cfg_d.max_hrv   = wdata_i;
        CFG_MIN_PULSE: cfg_d.min_pulse = wdata_i;
        CFG_MAX_PULSE: cfg_d.max_pulse = wdata_i;
        CFG_PEAK:      cfg_d.peak      = wdata_i[BRT_W-1:0];
        default:       cfg_d = cfg_q; // unknown index ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_hrv   <= MIN_HRV_RST;
      cfg_q.max_hrv   <= MAX_HRV_RST;
      cfg_q.min_pulse <= MIN_PULSE_RST;
      cfg_q.max_pulse <= MAX_PULSE_RST;
      cfg_q.peak      <= PEAK_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/hpbr_div.sv @@
// shared iterative unsigned divider, restoring, two quotient bits per cycle
// depends on hpbr_pkg

module hpbr_div import hpbr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hpbr_div_req_t req_i,
  output hpbr_div_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_D_W-1:0]   rem_q, rem_d;
  logic [DIV_N_W-1:0]   quo_q, quo_d;
  logic [DIV_D_W-1:0]   den_q, den_d;

  logic [DIV_D_W:0]   t1, t2, s1, s2;
  logic               b1, b2;
  logic [DIV_D_W-1:0] r1, r2;

  // two restoring steps; partial remainder stays below the divisor
  always_comb begin
    t1 = {rem_q, quo_q[DIV_N_W-1]};
    s1 = t1 - {1'b0, den_q};
    b1 = (t1 >= {1'b0, den_q});
    r1 = b1 ? s1[DIV_D_W-1:0] : t1[DIV_D_W-1:0];
    t2 = {r1, quo_q[DIV_N_W-2]};
    s2 = t2 - {1'b0, den_q};
    b2 = (t2 >= {1'b0, den_q});
    r2 = b2 ? s2[DIV_D_W-1:0] : t2[DIV_D_W-1:0];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_STEPS);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      den_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = r2;
      quo_d = {quo_q[DIV_N_W-3:0], b1, b2};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

  a_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !req_i.start && cnt_q == DIV_CNT_W'(1)) |=> done_q)
    else $error("divider missed its done pulse");

endmodule

@@ rtl/hrv_paced_brightness_ramp_unit.sv @@
// top level of the hrv paced brightness ramp: sequencer, shared multiplier, output register
// depends on hpbr_pkg, hpbr_ifs, hpbr_cfg_regs, hpbr_div
// flow: each transaction takes up to three passes through the shared divider; the ramp division
//   is skipped when the fade turns, the permille division when max_hrv <= min_hrv
// input ready only while idle, so a new transaction is taken only after the last result is in the output register
// reset: fade out phase, last toggle time 0, registers at their defaults, no result pending

module hrv_paced_brightness_ramp_unit import hpbr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  hpbr_in_if.sink               in_i,
  hpbr_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // sequencer state codes
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_MUL_SCALE = 4'd1;  // (h - min) * 1000
  localparam logic [3:0] S_PERM_ST   = 4'd2;  // start permille division
  localparam logic [3:0] S_PERM_WT   = 4'd3;
  localparam logic [3:0] S_MUL_SPAN  = 4'd4;  // permille * pulse span
  localparam logic [3:0] S_MS_ST     = 4'd5;  // start division by 1000
  localparam logic [3:0] S_MS_WT     = 4'd6;
  localparam logic [3:0] S_DUR       = 4'd7;  // compare elapsed with duration, toggle
  localparam logic [3:0] S_MUL_RAMP  = 4'd8;  // elapsed * peak
  localparam logic [3:0] S_RAMP_ST   = 4'd9;  // start ramp division
  localparam logic [3:0] S_RAMP_WT   = 4'd10;
  localparam logic [3:0] S_DONE      = 4'd11; // hand result to output register

  hpbr_cfg_t     cfg;
  hpbr_div_req_t div_req;
  hpbr_div_rsp_t div_rsp;

  logic [3:0]               state_q, state_d;
  logic [HRV_W-1:0]         diff_q, diff_d;
  logic [TIME_W-1:0]        now_q, now_d;
  logic [TIME_W-1:0]        elapsed_q, elapsed_d;
  logic signed [MUL_P_W-1:0] mul_q, mul_d;
  logic [PERM_W-1:0]        perm_q, perm_d;
  logic                     neg_q, neg_d;
  logic [PULSE_W-1:0]       dur_q, dur_d;
  logic [BRT_W-1:0]         ramp_q, ramp_d;
  logic [TIME_W-1:0]        last_toggle_q, last_toggle_d;
  logic                     fade_q, fade_d;
  logic                     out_valid_q, out_valid_d;
  logic [BRT_W-1:0]         out_brt_q, out_brt_d;
  logic                     out_fade_q, out_fade_d;

  logic                      in_acc;
  logic                      window_ok;
  logic [HRV_W-1:0]          hrv_clamped;
  logic signed [MUL_A_W-1:0] span;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic [MUL_P_W-1:0]        mul_neg;
  logic [DIV_N_W-1:0]        q_mag;
  logic signed [17:0]        quot_s;
  logic signed [17:0]        dur_s;
  logic                      dur_reached;

  hpbr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  hpbr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  // clamp only matters when the variability window is non-empty
  assign window_ok   = (cfg.max_hrv > cfg.min_hrv);
  assign hrv_clamped = (in_i.hrv_value < cfg.min_hrv) ? cfg.min_hrv :
                       (in_i.hrv_value > cfg.max_hrv) ? cfg.max_hrv : in_i.hrv_value;

  // signed pulse span, may be negative for an inverted pulse range
  assign span = $signed({1'b0, cfg.max_pulse}) - $signed({1'b0, cfg.min_pulse});

  // shared multiplier, operands picked by the sequencer
  always_comb begin
    unique case (state_q)
      S_MUL_SCALE: begin
        mul_a = $signed({1'b0, diff_q});
        mul_b = $signed(PERMILLE_FULL[MUL_B_W-1:0]);
      end
      S_MUL_SPAN: begin
        mul_a = span;
        mul_b = $signed({1'b0, perm_q});
      end
      S_MUL_RAMP: begin
        mul_a = $signed({1'b0, elapsed_q[PULSE_W-1:0]});
        mul_b = $signed({3'b000, cfg.peak});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign mul_neg = -mul_q;

  // divider requests; the ramp division only runs when elapsed < duration,
  // so its dividend fits in 24 bits and its quotient stays below peak
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = mul_q[DIV_N_W-1:0];
    div_req.divisor  = dur_q;
    unique case (state_q)
      S_PERM_ST: begin
        div_req.start   = 1'b1;
        div_req.divisor = cfg.max_hrv - cfg.min_hrv;
      end
      S_MS_ST: begin
        div_req.start    = 1'b1;
        div_req.dividend = neg_q ? mul_neg[DIV_N_W-1:0] : mul_q[DIV_N_W-1:0];
        div_req.divisor  = PERMILLE_FULL;
      end
      S_RAMP_ST: begin
        div_req.start = 1'b1;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // floor division of a signed product: round the magnitude up when negative
  always_comb begin
    q_mag  = div_rsp.quot + DIV_N_W'(neg_q && (div_rsp.rem != '0));
    quot_s = neg_q ? -$signed({1'b0, q_mag[16:0]}) : $signed({1'b0, q_mag[16:0]});
    dur_s  = $signed({2'b00, cfg.min_pulse}) + quot_s;
  end

  assign dur_reached = (elapsed_q >= {{(TIME_W-PULSE_W){1'b0}}, dur_q});

  // sequencer
  always_comb begin
    state_d       = state_q;
    diff_d        = diff_q;
    now_d         = now_q;
    elapsed_d     = elapsed_q;
    mul_d         = mul_q;
    perm_d        = perm_q;
    neg_d         = neg_q;
    dur_d         = dur_q;
    ramp_d        = ramp_q;
    last_toggle_d = last_toggle_q;
    fade_d        = fade_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    out_brt_d     = out_brt_q;
    out_fade_d    = out_fade_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          diff_d    = hrv_clamped - cfg.min_hrv;
          now_d     = in_i.now_ms;
          elapsed_d = in_i.now_ms - last_toggle_q; // wraps mod 2^32
          state_d   = S_MUL_SCALE;
        end
      end
      S_MUL_SCALE: begin
        mul_d = mul_p;
        if (window_ok) begin
          state_d = S_PERM_ST;
        end else begin
          // empty variability window gives permille 0
          perm_d  = '0;
          state_d = S_MUL_SPAN;
        end
      end
      S_PERM_ST: begin
        state_d = S_PERM_WT;
      end
      S_PERM_WT: begin
        if (div_rsp.done) begin
          perm_d  = div_rsp.quot[PERM_W-1:0];
          state_d = S_MUL_SPAN;
        end
      end
      S_MUL_SPAN: begin
        mul_d   = mul_p;
        neg_d   = mul_p[MUL_P_W-1];
        state_d = S_MS_ST;
      end
      S_MS_ST: begin
        state_d = S_MS_WT;
      end
      S_MS_WT: begin
        if (div_rsp.done) begin
          // zero-length fade forced to one millisecond
          dur_d   = (dur_s < 18'sd1) ? PULSE_W'(1) : dur_s[PULSE_W-1:0];
          state_d = S_DUR;
        end
      end
      S_DUR: begin
        if (dur_reached) begin
          // fade turns; ramp saturates at peak for the elapsed value seen here
          fade_d        = !fade_q;
          last_toggle_d = now_q;
          ramp_d        = cfg.peak;
          state_d       = S_DONE;
        end else begin
          state_d = S_MUL_RAMP;
        end
      end
      S_MUL_RAMP: begin
        mul_d   = mul_p;
        state_d = S_RAMP_ST;
      end
      S_RAMP_ST: begin
        state_d = S_RAMP_WT;
      end
      S_RAMP_WT: begin
        if (div_rsp.done) begin
          ramp_d  = div_rsp.quot[BRT_W-1:0];
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // output register frees up once the pending result is taken
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_brt_d   = fade_q ? ramp_q : (cfg.peak - ramp_q);
          out_fade_d  = fade_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      last_toggle_q <= '0;
      fade_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      last_toggle_q <= last_toggle_d;
      fade_q        <= fade_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q     <= diff_d;
    now_q      <= now_d;
    elapsed_q  <= elapsed_d;
    mul_q      <= mul_d;
    perm_q     <= perm_d;
    neg_q      <= neg_d;
    dur_q      <= dur_d;
    ramp_q     <= ramp_d;
    out_brt_q  <= out_brt_d;
    out_fade_q <= out_fade_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.brightness = out_brt_q;
  assign out_o.fading_up  = out_fade_q;

  a_brt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_brt_q <= cfg.peak))
    else $error("brightness above peak");

  a_idle_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !div_rsp.busy)
    else $error("divider busy while sequencer idle");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_PERM_WT || state_q == S_MS_WT || state_q == S_RAMP_WT))
    else $error("divider result outside a wait state");

  a_ramp_below_dur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL_RAMP) |-> (dur_q != '0 && !dur_reached))
    else $error("ramp division started with elapsed at or beyond duration");

endmodule
